// File: sv/multi_button_edge_debouncer_top_defines.svh
// ----------------------------------------------------------------------------
// multi_button_edge_debouncer_top_defines.svh
// Assertion macros used by the debouncer top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_EDGE_DEBOUNCER_TOP_DEFINES_SVH
`define MULTI_BUTTON_EDGE_DEBOUNCER_TOP_DEFINES_SVH

// Clocked assertion, quiet while reset is asserted
`define MBED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define MBED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mbed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbed_pkg
// Types and constants shared by the button debouncer modules.
// ----------------------------------------------------------------------------
package mbed_pkg;

    // Debounced lane state codes
    typedef enum logic [1:0] {
        ST_HIGH    = 2'd0,
        ST_FALLING = 2'd1,
        ST_LOW     = 2'd2,
        ST_RISING  = 2'd3
    } lane_state_t;

    // Register select, taken from paddr[2]
    localparam logic REG_ACTIVE = 1'b0;
    localparam logic REG_STABLE = 1'b1;

    localparam int RAW_W      = 8;
    localparam int OUT_LANES  = 8;
    localparam int THR_W      = 8;
    localparam int CNT_W      = 8;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int ACT_WR_W   = 4;
    localparam logic [THR_W-1:0] STABLE_RESET = 8'd10;

    // Per-lane control from the top level
    typedef struct packed {
        logic             clear;
        logic             tick;
        logic [THR_W-1:0] stable_ticks;
    } lane_ctrl_t;

    // Configuration events to the datapath
    typedef struct packed {
        logic             clear_lanes;
        logic [THR_W-1:0] stable_ticks;
    } cfg_status_t;

endpackage

// File: sv/mbed_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbed_lane
// One debounce lane: four-state debounced value and disagreement counter.
// ----------------------------------------------------------------------------
module mbed_lane
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbed_pkg::lane_ctrl_t ctrl,
    input  logic                 level,
    output logic [1:0]           state
);
    import mbed_pkg::*;

    lane_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    lane_state_t       settled;
    logic [CNT_W-1:0]  count_inc;
    logic              settled_lvl;

    // Settle one-tick edge states, then compare against the raw level
    always_comb
    begin
        case (state_reg)
            ST_FALLING: settled = ST_LOW;
            ST_RISING:  settled = ST_HIGH;
            ST_HIGH:    settled = ST_HIGH;
            ST_LOW:     settled = ST_LOW;
            default:    settled = ST_HIGH;
        endcase
        settled_lvl = (settled == ST_HIGH);
        count_inc   = count_reg + CNT_W'(1);
        state_next  = state_reg;
        count_next  = count_reg;
        if (ctrl.clear)
        begin
            state_next = ST_HIGH;
            count_next = '0;
        end
        else if (ctrl.tick)
        begin
            state_next = settled;
            if (level == settled_lvl)
            begin
                count_next = '0;
            end
            else if (count_inc == ctrl.stable_ticks)
            begin
                count_next = '0;
                state_next = settled_lvl ? ST_FALLING : ST_RISING;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    // Hold lane state and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HIGH;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign state = state_reg;

endmodule

// File: sv/mbed_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbed_cfg
// APB register file: active lane count and stable tick threshold.
// ----------------------------------------------------------------------------
module mbed_cfg
#(
    parameter int NUM_LANES = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbed_pkg::ADDR_W-1:0]         paddr,
    input  logic [mbed_pkg::DATA_W-1:0]         pwdata,
    output logic [mbed_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    output logic [$clog2(NUM_LANES+1)-1:0]      active_count,
    output mbed_pkg::cfg_status_t               status
);
    import mbed_pkg::*;

    localparam int AW  = $clog2(NUM_LANES + 1);
    localparam int SW  = 6;

    logic [AW-1:0]    active_reg, active_next;
    logic [THR_W-1:0] stable_reg, stable_next;
    logic             wr_en;
    logic             wr_active;
    logic [SW-1:0]    wr_count;
    logic [SW-1:0]    sat_count;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign wr_active = wr_en && (paddr[2] == REG_ACTIVE);

    // Saturate the written lane count to the lanes present
    always_comb
    begin
        wr_count    = SW'(pwdata[ACT_WR_W-1:0]);
        sat_count   = (wr_count > SW'(NUM_LANES)) ? SW'(NUM_LANES) : wr_count;
        active_next = active_reg;
        stable_next = stable_reg;
        if (wr_active)
            active_next = AW'(sat_count);
        if (wr_en && (paddr[2] == REG_STABLE))
            stable_next = pwdata[THR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            stable_reg <= STABLE_RESET;
        end
        else
        begin
            active_reg <= active_next;
            stable_reg <= stable_next;
        end
    end

    // Read back
    assign prdata = (paddr[2] == REG_ACTIVE) ? DATA_W'(active_reg) : DATA_W'(stable_reg);

    assign active_count        = active_reg;
    assign status.clear_lanes  = wr_active;
    assign status.stable_ticks = stable_reg;

endmodule

// File: sv/multi_button_edge_debouncer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_edge_debouncer_top
// Multi-lane counter-based button debouncer with stream ports and APB config.
// ----------------------------------------------------------------------------
// Each input word is one sample tick holding a raw level per lane. It is
// captured in an input register and, once the result slot is free, every
// active lane updates its debounced state and disagreement counter in
// parallel; the lane state registers then form the result word (two bits
// per lane: 0 high, 1 falling, 2 low, 3 rising). One word per cycle is
// sustained while m_tready is high. Writing the active lane count
// (address 0) puts all lanes back to high; address 4 holds the threshold.
// Configure only while no word is in flight.
module multi_button_edge_debouncer_top
#(
    parameter int NUM_LANES = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // stream in
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] raw_levels
    // stream out
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [15:0] lane_states
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mbed_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbed_pkg::DATA_W-1:0]  pwdata,
    output logic [mbed_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import mbed_pkg::*;

    `include "multi_button_edge_debouncer_top_defines.svh"

    localparam int AW = $clog2(NUM_LANES + 1);

    logic             in_valid_reg, in_valid_next;
    logic [RAW_W-1:0] in_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic [AW-1:0]    active_count;
    cfg_status_t      cfg;
    logic [1:0]       lane_state [NUM_LANES];

    // Register file
    mbed_cfg #(.NUM_LANES(NUM_LANES)) u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .active_count (active_count),
        .status       (cfg)
    );

    // Advance the held word into the lanes when the result slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
    end

    // Lanes
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        lane_ctrl_t ctrl;
        logic       level;

        assign ctrl.clear        = cfg.clear_lanes;
        assign ctrl.tick         = advance && (AW'(i) < active_count);
        assign ctrl.stable_ticks = cfg.stable_ticks;

        if (i < RAW_W)
        begin : g_in
            assign level = in_data_reg[i];
        end
        else
        begin : g_nin
            assign level = 1'b0;
        end

        mbed_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .level (level),
            .state (lane_state[i])
        );
    end

    // Pack the reported lanes; missing lanes read as zero
    for (genvar j = 0; j < OUT_LANES; j++)
    begin : g_pack
        if (j < NUM_LANES)
        begin : g_on
            assign m_tdata[2*j +: 2] = lane_state[j];
        end
        else
        begin : g_off
            assign m_tdata[2*j +: 2] = 2'b00;
        end
    end

    assign m_tvalid = out_valid_reg;

    // Checks
    `MBED_ASSERT(a_clear_all_high, cfg.clear_lanes |=> (m_tdata == 16'h0000),
        "lanes not back to high after active count write")
    `MBED_ASSERT(a_hold_when_idle, (!advance && !cfg.clear_lanes) |=> $stable(m_tdata),
        "lane states changed without a word")
    `MBED_ASSERT(a_full_blocks, (in_valid_reg && !advance) |-> !s_tready,
        "input taken while the held word is blocked")
    `MBED_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> (!m_tvalid && s_tready),
        "pipeline not empty in reset")

endmodule
